FILE: src/ddct_pkg.sv
// Shared types, register codes and per-timer update logic for the dual
// down-counter timer unit. No dependencies.
`default_nettype none
package ddct_pkg;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_CROSS     = 2'd2,
        ST_UNHANDLED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_LOAD    = 3'd0,
        REG_VALUE   = 3'd1,
        REG_CONTROL = 3'd2,
        REG_INTCLR  = 3'd3,
        REG_RIS     = 3'd4,
        REG_MIS     = 3'd5,
        REG_BGLOAD  = 3'd6,
        REG_UNUSED  = 3'd7
    } reg_sel_t;

    localparam int CTL_ENABLE   = 7;
    localparam int CTL_PERIODIC = 6;
    localparam int CTL_INTEN    = 5;
    localparam int CTL_SIZE32   = 1;
    localparam int CTL_ONESHOT  = 0;

    localparam logic [7:0]  CTL_RESET    = 8'h20;
    localparam logic [31:0] COUNT_RESET  = 32'hFFFF_FFFF;
    localparam logic [31:0] MASK_16      = 32'h0000_FFFF;
    localparam logic [12:0] WINDOW_BYTES = 13'h1000;
    localparam logic [6:0]  ID_BLOCK     = 7'h7F;

    typedef struct packed {
        logic [31:0] load;
        logic [31:0] count;
        logic [7:0]  ctl;
        logic        raw;
        logic [7:0]  pre;
    } timer_t;

    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h04;
            3'd1:    b = 8'h18;
            3'd2:    b = 8'h14;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'hF0;
            3'd6:    b = 8'h05;
            default: b = 8'hB1;
        endcase
        return b;
    endfunction

    function automatic timer_t timer_tick(input timer_t t);
        timer_t      n;
        logic [8:0]  pre_limit;
        logic [31:0] mask;
        logic [31:0] act;
        logic [31:0] act_dec;
        logic        expire;
        n       = t;
        expire  = 1'b0;
        mask    = t.ctl[CTL_SIZE32] ? COUNT_RESET : MASK_16;
        act     = t.count & mask;
        act_dec = (act - 32'd1) & mask;
        case (t.ctl[3:2])
            2'd1:    pre_limit = 9'd16;
            2'd2:    pre_limit = 9'd256;
            default: pre_limit = 9'd1;
        endcase
        if (t.ctl[CTL_ENABLE]) begin
            if (({1'b0, t.pre} + 9'd1) < pre_limit) begin
                n.pre = t.pre + 8'd1;
            end else begin
                n.pre = 8'd0;
                if (act == 32'd0) begin
                    expire = !t.ctl[CTL_ONESHOT];
                end else begin
                    n.count = (t.count & ~mask) | act_dec;
                    expire  = (act_dec == 32'd0);
                end
            end
        end
        if (expire) begin
            n.raw = 1'b1;
            if (t.ctl[CTL_ONESHOT]) begin
                n.count = 32'd0;
            end else if (t.ctl[CTL_PERIODIC]) begin
                n.count = t.load;
            end else begin
                n.count = COUNT_RESET;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: src/dual_down_counter_timer_unit.sv
// Dual down-counter timer unit: register file, bus access decode and timer update.
// Depends on ddct_pkg.
//
// Usage: each item on the s_ channel is a bus read, a bus write or a
// clock-enable tick (s_func). Every item yields exactly one result item on
// the m_ channel: read data, an access status and the masked interrupts as
// they stand after the item.
// Flow: an accepted item waits in the input register, is processed there and
// moves into the result register once that register is free or its result is
// taken; its result then shows on m_valid.
// Throughput: one item per cycle while m_ready is high; timer state is updated
// in the same cycle an item leaves the input register, so the next item sees it.
// Reset: aresetn (synchronous, active low) empties both registers and puts
// both timers in their reset state (load 0, count all ones, control 0x20).
// Stall: while m_ready is low the result register holds; one more item is
// taken into the input register, then s_ready drops until the result leaves.
`default_nettype none
module dual_down_counter_timer_unit import ddct_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_func,
    input  wire  [11:0] s_addr,
    input  wire  [2:0]  s_size,
    input  wire  [31:0] s_wdata,
    input  wire         s_tick_timer1,
    input  wire         s_tick_timer2,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_rdata,
    output logic [1:0]  m_status,
    output logic        m_irq1,
    output logic        m_irq2,
    output logic        m_irq_combined
);

    logic        in_valid_reg;
    logic [1:0]  func_reg;
    logic [11:0] addr_reg;
    logic [2:0]  size_reg;
    logic [31:0] wdata_reg;
    logic [1:0]  tick_reg;

    timer_t      timer_reg  [2];
    timer_t      timer_next [2];

    logic        out_valid_reg;
    logic [31:0] rdata_reg;
    logic [31:0] rdata_next;
    status_t     status_reg;
    status_t     status_next;
    logic [1:0]  irq_reg;
    logic [1:0]  irq_next;

    logic        advance;
    logic        t_idx;
    reg_sel_t    sel;
    logic [12:0] end_addr;
    logic [3:0]  end_byte;
    logic [1:0]  off;
    logic [3:0]  be;
    logic [31:0] bmask;
    logic [31:0] cur;
    logic [31:0] nv;
    logic [4:0]  shamt;
    timer_t      tsel;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign t_idx    = addr_reg[5];
    assign sel      = reg_sel_t'(addr_reg[4:2]);
    assign off      = addr_reg[1:0];
    assign shamt    = {off, 3'b000};
    assign end_addr = {1'b0, addr_reg} + {10'd0, size_reg};
    assign end_byte = {2'b00, off} + {1'b0, size_reg};
    assign tsel     = timer_reg[t_idx];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            be[i] = (3'(i) >= {1'b0, off}) && (4'(i) < end_byte);
            bmask[8*i +: 8] = {8{be[i]}};
        end
    end

    always_comb begin
        cur = 32'd0;
        if (addr_reg[11:6] == 6'd0) begin
            case (sel)
                REG_LOAD:    cur = tsel.load;
                REG_VALUE:   cur = tsel.count;
                REG_CONTROL: cur = {24'd0, tsel.ctl};
                REG_RIS:     cur = {31'd0, tsel.raw};
                REG_MIS:     cur = {31'd0, tsel.raw & tsel.ctl[CTL_INTEN]};
                REG_BGLOAD:  cur = tsel.load;
                default:     cur = 32'd0;
            endcase
        end else if (addr_reg[11:5] == ID_BLOCK) begin
            cur = {24'd0, id_byte(addr_reg[4:2])};
        end
    end

    assign nv = (cur & ~bmask) | ((wdata_reg << shamt) & bmask);

    always_comb begin
        timer_next[0] = timer_reg[0];
        timer_next[1] = timer_reg[1];
        rdata_next    = 32'd0;
        status_next   = ST_OK;
        case (func_t'(func_reg))
            FUNC_TICK: begin
                for (int i = 0; i < 2; i++) begin
                    if (tick_reg[i]) begin
                        timer_next[i] = timer_tick(timer_reg[i]);
                    end
                end
            end
            FUNC_READ, FUNC_WRITE: begin
                if (end_addr > WINDOW_BYTES) begin
                    status_next = ST_RANGE;
                end else if (size_reg == 3'd0 || end_byte > 4'd4) begin
                    status_next = ST_CROSS;
                end else if (func_t'(func_reg) == FUNC_READ) begin
                    rdata_next = (cur & bmask) >> shamt;
                end else if (addr_reg[11:6] != 6'd0) begin
                    status_next = ST_UNHANDLED;
                end else begin
                    case (sel)
                        REG_LOAD: begin
                            timer_next[t_idx].load  = nv;
                            timer_next[t_idx].count = nv;
                            timer_next[t_idx].pre   = 8'd0;
                        end
                        REG_VALUE: begin
                            status_next = ST_OK;
                        end
                        REG_CONTROL: begin
                            if (tsel.ctl[CTL_ENABLE] && nv[CTL_ENABLE]
                                    && tsel.ctl != nv[7:0]) begin
                                status_next = ST_UNHANDLED;
                            end
                            if (!tsel.ctl[CTL_ENABLE] && nv[CTL_ENABLE]) begin
                                timer_next[t_idx].pre = 8'd0;
                            end
                            timer_next[t_idx].ctl = nv[7:0];
                        end
                        REG_INTCLR: begin
                            timer_next[t_idx].raw = 1'b0;
                        end
                        REG_BGLOAD: begin
                            timer_next[t_idx].load = nv;
                        end
                        default: begin
                            status_next = ST_UNHANDLED;
                        end
                    endcase
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
        for (int i = 0; i < 2; i++) begin
            irq_next[i] = timer_next[i].raw & timer_next[i].ctl[CTL_INTEN];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                timer_reg[i] <= '{load: 32'd0, count: COUNT_RESET, ctl: CTL_RESET,
                                  raw: 1'b0, pre: 8'd0};
            end
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                timer_reg[0]  <= timer_next[0];
                timer_reg[1]  <= timer_next[1];
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            func_reg  <= s_func;
            addr_reg  <= s_addr;
            size_reg  <= s_size;
            wdata_reg <= s_wdata;
            tick_reg  <= {s_tick_timer2, s_tick_timer1};
        end
        if (advance) begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
            irq_reg    <= irq_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_rdata        = rdata_reg;
    assign m_status       = status_reg;
    assign m_irq1         = irq_reg[0];
    assign m_irq2         = irq_reg[1];
    assign m_irq_combined = irq_reg[0] | irq_reg[1];

endmodule
`default_nettype wire

FILE: src/ddct_checker.sv
// Port-level checker for dual_down_counter_timer_unit, bound to the top level.
// Depends on ddct_pkg.
`default_nettype none
module ddct_checker import ddct_pkg::*; (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire [31:0] m_rdata,
    input wire [1:0]  m_status,
    input wire        m_irq1,
    input wire        m_irq2,
    input wire        m_irq_combined
);

    a_irq_or: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_irq_combined == (m_irq1 | m_irq2)))
        else $error("combined interrupt is not the OR of the masked ones");

    a_err_rdata_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_rdata == 32'd0))
        else $error("item with error status carries read data");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rdata) && $stable(m_status)))
        else $error("stalled result item changed");

endmodule

bind dual_down_counter_timer_unit ddct_checker u_ddct_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_rdata        (m_rdata),
    .m_status       (m_status),
    .m_irq1         (m_irq1),
    .m_irq2         (m_irq2),
    .m_irq_combined (m_irq_combined)
);
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for dual_down_counter_timer_unit: bus reads, writes and
// clock-enable ticks are checked against an in-bench timer predictor.
// Depends on ddct_pkg and the timer unit RTL.
module tb_top;
    import ddct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HOLD_CYCLES      = 150;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          RANDOM_PER_PHASE = 200;
    localparam logic [11:0] TIMER_SPAN       = 12'h040;
    localparam logic [11:0] ID_BASE          = 12'hFE0;
    localparam logic [63:0] ID_BYTES         = 64'hB105_F00D_0014_1804;
    localparam logic [1:0]  PRE_DIV1         = 2'd0;
    localparam logic [1:0]  PRE_DIV16        = 2'd1;
    localparam logic [1:0]  PRE_DIV256       = 2'd2;
    localparam logic [1:0]  PRE_DIV1_ALT     = 2'd3;
    localparam logic [7:0]  C_EN             = 8'h01 << CTL_ENABLE;
    localparam logic [7:0]  C_PER            = 8'h01 << CTL_PERIODIC;
    localparam logic [7:0]  C_IE             = 8'h01 << CTL_INTEN;
    localparam logic [7:0]  C_32             = 8'h01 << CTL_SIZE32;
    localparam logic [7:0]  C_ONE            = 8'h01 << CTL_ONESHOT;
    localparam logic [7:0]  C_PRE16          = {4'd0, PRE_DIV16, 2'd0};

    typedef struct packed {
        logic [31:0] rdata;
        status_t     status;
        logic        irq1;
        logic        irq2;
        logic        irq_combined;
    } timer_result_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    func_t       s_func  = FUNC_READ;
    logic [11:0] s_addr  = '0;
    logic [2:0]  s_size  = '0;
    logic [31:0] s_wdata = '0;
    logic        s_tick_timer1 = 1'b0;
    logic        s_tick_timer2 = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_rdata;
    logic [1:0]  m_status;
    logic        m_irq1;
    logic        m_irq2;
    logic        m_irq_combined;

    logic [31:0] tmr_load  [2];
    logic [31:0] tmr_count [2];
    logic [7:0]  tmr_ctl   [2];
    logic        tmr_raw   [2];
    logic [7:0]  tmr_pre   [2];

    timer_result_t expected_results[$];
    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int expiries        = 0;
    int stall_cycles    = 0;
    int quiet_cycles    = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_count      = 0;

    dual_down_counter_timer_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_addr         (s_addr),
        .s_size         (s_size),
        .s_wdata        (s_wdata),
        .s_tick_timer1  (s_tick_timer1),
        .s_tick_timer2  (s_tick_timer2),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rdata        (m_rdata),
        .m_status       (m_status),
        .m_irq1         (m_irq1),
        .m_irq2         (m_irq2),
        .m_irq_combined (m_irq_combined)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------- timer predictor ----------------

    function automatic void clear_timers();
        for (int t = 0; t < 2; t++) begin
            tmr_load[t]  = '0;
            tmr_count[t] = 32'hFFFF_FFFF;
            tmr_ctl[t]   = C_IE;
            tmr_raw[t]   = 1'b0;
            tmr_pre[t]   = '0;
        end
    endfunction

    function automatic void fire_timer(input int t);
        expiries++;
        tmr_raw[t] = 1'b1;
        if (tmr_ctl[t][CTL_ONESHOT]) begin
            tmr_count[t] = '0;
        end else if (tmr_ctl[t][CTL_PERIODIC]) begin
            tmr_count[t] = tmr_load[t];
        end else begin
            tmr_count[t] = 32'hFFFF_FFFF;
        end
    endfunction

    function automatic void advance_timer(input int t);
        int unsigned div;
        logic [31:0] span;
        logic [31:0] act;
        if (!tmr_ctl[t][CTL_ENABLE]) return;
        case (tmr_ctl[t][3:2])
            PRE_DIV16:  div = 16;
            PRE_DIV256: div = 256;
            default:    div = 1;
        endcase
        if (tmr_pre[t] + 1 < div) begin
            tmr_pre[t] = tmr_pre[t] + 8'd1;
            return;
        end
        tmr_pre[t] = '0;
        span = tmr_ctl[t][CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        act  = tmr_count[t] & span;
        if (act == 32'd0) begin
            if (!tmr_ctl[t][CTL_ONESHOT]) fire_timer(t);
            return;
        end
        act = (act - 32'd1) & span;
        tmr_count[t] = (tmr_count[t] & ~span) | act;
        if (act == 32'd0) fire_timer(t);
    endfunction

    function automatic logic [31:0] register_word(input logic [11:0] w);
        int t;
        logic [31:0] v;
        t = int'(w[5]);
        v = '0;
        if (w < TIMER_SPAN) begin
            case (reg_sel_t'(w[4:2]))
                REG_LOAD, REG_BGLOAD: v = tmr_load[t];
                REG_VALUE:            v = tmr_count[t];
                REG_CONTROL:          v = {24'd0, tmr_ctl[t]};
                REG_RIS:              v = {31'd0, tmr_raw[t]};
                REG_MIS:              v = {31'd0, tmr_raw[t] & tmr_ctl[t][CTL_INTEN]};
                default:              v = '0;
            endcase
        end else if (w >= ID_BASE) begin
            v = {24'd0, ID_BYTES[8 * w[4:2] +: 8]};
        end
        return v;
    endfunction

    function automatic status_t store_word(input logic [11:0] w, input logic [31:0] v);
        int t;
        logic [7:0] prev;
        status_t st;
        t  = int'(w[5]);
        st = ST_OK;
        if (w >= TIMER_SPAN) return ST_UNHANDLED;
        case (reg_sel_t'(w[4:2]))
            REG_LOAD: begin
                tmr_load[t]  = v;
                tmr_count[t] = v;
                tmr_pre[t]   = '0;
            end
            REG_VALUE: ;
            REG_CONTROL: begin
                prev = tmr_ctl[t];
                if (prev[CTL_ENABLE] && v[CTL_ENABLE] && prev != v[7:0]) st = ST_UNHANDLED;
                if (!prev[CTL_ENABLE] && v[CTL_ENABLE]) tmr_pre[t] = '0;
                tmr_ctl[t] = v[7:0];
            end
            REG_INTCLR: tmr_raw[t]  = 1'b0;
            REG_BGLOAD: tmr_load[t] = v;
            default:    st = ST_UNHANDLED;
        endcase
        return st;
    endfunction

    function automatic timer_result_t predict_item(input func_t fn, input logic [11:0] addr,
                                                   input logic [2:0] nbytes,
                                                   input logic [31:0] data,
                                                   input logic t1, input logic t2);
        timer_result_t r;
        logic [63:0]   lanes;
        logic [63:0]   picked;
        logic [31:0]   cur;
        logic [4:0]    shift;
        r = '0;
        r.status = ST_OK;
        if (fn == FUNC_TICK) begin
            if (t1) advance_timer(0);
            if (t2) advance_timer(1);
        end else if (fn == FUNC_READ || fn == FUNC_WRITE) begin
            if ({1'b0, addr} + nbytes > WINDOW_BYTES) begin
                r.status = ST_RANGE;
            end else if (nbytes == 3'd0 || addr[1:0] + nbytes > 4) begin
                r.status = ST_CROSS;
            end else begin
                shift = {addr[1:0], 3'b000};
                lanes = ((64'd1 << (8 * nbytes)) - 64'd1) << shift;
                cur   = register_word({addr[11:2], 2'b00});
                if (fn == FUNC_READ) begin
                    picked  = ({32'd0, cur} & lanes) >> shift;
                    r.rdata = picked[31:0];
                end else begin
                    r.status = store_word({addr[11:2], 2'b00},
                                          (cur & ~lanes[31:0]) | ((data << shift) & lanes[31:0]));
                end
            end
        end
        r.irq1         = tmr_raw[0] & tmr_ctl[0][CTL_INTEN];
        r.irq2         = tmr_raw[1] & tmr_ctl[1][CTL_INTEN];
        r.irq_combined = r.irq1 | r.irq2;
        return r;
    endfunction

    // ---------------- item driver ----------------

    task automatic send_item(input func_t fn, input logic [11:0] addr, input logic [2:0] nbytes,
                             input logic [31:0] data, input logic t1, input logic t2);
        s_valid       <= 1'b1;
        s_func        <= fn;
        s_addr        <= addr;
        s_size        <= nbytes;
        s_wdata       <= data;
        s_tick_timer1 <= t1;
        s_tick_timer2 <= t2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_item(fn, addr, nbytes, data, t1, t2));
        items_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic logic [11:0] reg_addr(input logic t, input reg_sel_t sel);
        return {6'd0, t, sel, 2'b00};
    endfunction

    task automatic bus_read(input logic [11:0] addr, input logic [2:0] nbytes);
        send_item(FUNC_READ, addr, nbytes, $urandom, 1'b0, 1'b0);
    endtask

    task automatic bus_write(input logic [11:0] addr, input logic [2:0] nbytes,
                             input logic [31:0] data);
        send_item(FUNC_WRITE, addr, nbytes, data, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    task automatic tick(input logic t1, input logic t2);
        send_item(FUNC_TICK, 12'($urandom), 3'($urandom), $urandom, t1, t2);
    endtask

    // ---------------- result checker ----------------

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : check_result
        timer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got rdata %h status %0d",
                         $time, m_rdata, m_status);
                errors++;
            end else begin
                want = expected_results.pop_front();
                report_field("rdata", want.rdata, m_rdata);
                report_field("status", 32'(want.status), 32'(m_status));
                report_field("irq1", 32'(want.irq1), 32'(m_irq1));
                report_field("irq2", 32'(want.irq2), 32'(m_irq2));
                report_field("irq_combined", 32'(want.irq_combined), 32'(m_irq_combined));
                results_checked++;
            end
        end
    end

    initial begin : receiver
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_count != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (s_valid && !s_ready) stall_cycles <= stall_cycles + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [31:0] random_load();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return $urandom_range(0, 24);
        if (pick < 90) return $urandom_range(0, 300);
        return $urandom;
    endfunction

    function automatic logic [7:0] random_control();
        logic [7:0] c;
        int pick;
        c = 8'($urandom);
        c[CTL_ENABLE]  = ($urandom_range(99) < 80);
        c[CTL_INTEN]   = ($urandom_range(99) < 75);
        c[CTL_ONESHOT] = ($urandom_range(99) < 30);
        pick = $urandom_range(99);
        if (pick < 50)      c[3:2] = PRE_DIV1;
        else if (pick < 75) c[3:2] = PRE_DIV16;
        else if (pick < 90) c[3:2] = PRE_DIV1_ALT;
        else                c[3:2] = PRE_DIV256;
        return c;
    endfunction

    task automatic pick_lane(output logic [2:0] nbytes, output logic [1:0] off);
        case ($urandom_range(3))
            0: begin nbytes = 3'd4; off = 2'd0; end
            1: begin nbytes = 3'd2; off = {1'($urandom_range(1)), 1'b0}; end
            2: begin nbytes = 3'd1; off = 2'($urandom_range(3)); end
            default: begin nbytes = 3'd3; off = 2'($urandom_range(1)); end
        endcase
    endtask

    task automatic random_item();
        int         pick;
        logic       t;
        reg_sel_t   sel;
        logic [2:0] nbytes;
        logic [1:0] off;
        pick = $urandom_range(99);
        t    = 1'($urandom_range(1));
        sel  = reg_sel_t'($urandom_range(7));
        if (pick < 8) begin
            // program one timer, then run it for a while
            bus_write(reg_addr(t, $urandom_range(1) ? REG_LOAD : REG_BGLOAD), 3'd4,
                      random_load());
            bus_write(reg_addr(t, REG_CONTROL), 3'd4, {24'($urandom), random_control()});
            repeat ($urandom_range(3, 20)) tick($urandom_range(99) < 85, $urandom_range(99) < 85);
        end else if (pick < 48) begin
            tick($urandom_range(99) < 80, $urandom_range(99) < 80);
        end else if (pick < 56) begin
            bus_write(reg_addr(t, $urandom_range(3) == 0 ? REG_BGLOAD : REG_LOAD), 3'd4,
                      random_load());
        end else if (pick < 62) begin
            bus_write(reg_addr(t, REG_CONTROL), 3'd4, {24'($urandom), random_control()});
        end else if (pick < 66) begin
            bus_write(reg_addr(t, REG_INTCLR), 3'd4, $urandom);
        end else if (pick < 84) begin
            pick_lane(nbytes, off);
            bus_read(reg_addr(t, sel) | {10'd0, off}, nbytes);
        end else if (pick < 91) begin
            pick_lane(nbytes, off);
            bus_write(reg_addr(t, sel) | {10'd0, off}, nbytes, $urandom);
        end else begin
            send_item(func_t'($urandom_range(3)), 12'($urandom), 3'($urandom), $urandom,
                      1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_register_map();
        bus_read(reg_addr(1'b0, REG_LOAD), 3'd4);
        bus_read(reg_addr(1'b0, REG_VALUE), 3'd4);
        bus_read(reg_addr(1'b1, REG_CONTROL), 3'd4);
        bus_read(ID_BASE, 3'd4);
        bus_read(ID_BASE + 12'h01C, 3'd4);
        bus_read(12'h800, 3'd4);
        bus_write(reg_addr(1'b0, REG_LOAD), 3'd4, 32'hFFFF_FFFF);
        bus_read(reg_addr(1'b0, REG_BGLOAD) | 12'd2, 3'd2);
        bus_write(reg_addr(1'b1, REG_BGLOAD) | 12'd1, 3'd1, 32'h0000_00A5);
        bus_write(reg_addr(1'b0, REG_RIS), 3'd4, 32'd1);
        bus_write(ID_BASE + 12'h004, 3'd4, 32'd0);
        bus_write(reg_addr(1'b1, REG_VALUE), 3'd4, 32'h1234_5678);
        bus_read(12'hFFF, 3'd2);
        bus_read(12'h002, 3'd4);
        bus_read(12'h000, 3'd0);
        bus_read(12'h000, 3'd7);
        send_item(FUNC_NONE, 12'h000, 3'd4, 32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    task automatic test_timer_expiry();
        bus_write(reg_addr(1'b0, REG_LOAD), 3'd4, 32'd2);
        bus_write(reg_addr(1'b0, REG_CONTROL), 3'd4, {24'd0, C_EN | C_PER | C_IE | C_32});
        repeat (3) tick(1'b1, 1'b1);
        bus_write(reg_addr(1'b0, REG_INTCLR), 3'd4, 32'd0);
        bus_write(reg_addr(1'b0, REG_LOAD), 3'd4, 32'd0);
        tick(1'b1, 1'b0);
        bus_write(reg_addr(1'b0, REG_CONTROL), 3'd4,
                  {24'd0, C_EN | C_PER | C_IE | C_32 | C_PRE16});
        bus_read(reg_addr(1'b0, REG_MIS), 3'd4);
        bus_write(reg_addr(1'b1, REG_LOAD), 3'd4, 32'h0001_0001);
        bus_write(reg_addr(1'b1, REG_CONTROL), 3'd4, {24'd0, C_EN | C_IE | C_ONE});
        repeat (2) tick(1'b0, 1'b1);
        bus_read(reg_addr(1'b1, REG_VALUE), 3'd4);
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            target = items_sent + RANDOM_PER_PHASE;
            while (items_sent < target) random_item();
        end
    endtask

    task automatic test_input_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_count <= hold_count + 1;
        repeat (24) random_item();
    endtask

    initial begin
        clear_timers();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_register_map();
        test_timer_expiry();
        test_random_traffic();
        test_input_stall();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Ran %0d items (reads, writes, ticks, bad accesses) and checked %0d results;",
                 items_sent, results_checked);
        $display("%0d timer expiries predicted, input held off for %0d cycles.",
                 expiries, stall_cycles);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/ddct_pkg.sv
src/dual_down_counter_timer_unit.sv
src/ddct_checker.sv
tb/sv/tb_top.sv
